[design/skt_pkg.sv]
`default_nettype none

package skt_pkg;

	// Table size, the widths that follow from it, and the key and reported-count widths.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int ECNT_W   = 5;

	// Operation codes carried on the request tuser.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH,
		ST_REPORT
	} ctrl_state_t;

	// Result item, last field in the lowest bits.
	typedef struct packed {
		logic                table_empty;
		logic [ECNT_W-1:0]   entry_count;
		status_t             status;
	} result_t;

	localparam int RES_W = $bits(result_t);

	// Entry count as reported: the stored count taken modulo 32.
	function automatic logic [ECNT_W-1:0] entry_bits(input cnt_t cnt);
		logic [CNT_W+ECNT_W-1:0] wide;
		wide = {{ECNT_W{1'b0}}, cnt};
		return wide[ECNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

[design/skt_ram.sv]
`default_nettype none

module skt_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/skt_ctrl.sv]
`default_nettype none

module skt_ctrl
	import skt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request side.
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  req_op,
	input  wire key_t        req_key,
	// Result side.
	output logic             res_valid,
	input  wire logic        res_ready,
	output result_t          res,
	// Key memory.
	output logic             ram_we,
	output idx_t             ram_waddr,
	output logic [KEY_W-1:0] ram_wdata,
	output logic             ram_re,
	output idx_t             ram_raddr,
	input  wire logic [KEY_W-1:0] ram_rdata
);

	ctrl_state_t state_q, state_d;
	logic [1:0]  op_q;
	key_t        key_q;
	cnt_t        cnt_q;
	cnt_t        rd_idx_q;
	logic        rd_vld_s1;
	idx_t        rd_pos_s1;
	logic        found_q;
	logic [KEY_W-1:0] carry_q;
	status_t     status_q;

	logic        req_full;
	logic        req_skip;
	logic        key_ge;
	logic        key_eq;

	assign req_full = (req_op == OP_INSERT) && (cnt_q == cnt_t'(CAPACITY));
	assign req_skip = req_full || ((req_op != OP_INSERT) && (req_op != OP_DELETE)
		&& (req_op != OP_SEARCH));
	assign key_ge   = $signed(ram_rdata) >= key_q;
	assign key_eq   = ram_rdata == key_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = req_skip ? ST_REPORT : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if ((rd_idx_q == cnt_q) && !rd_vld_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// Handshakes and memory accesses. A write always trails the read address,
	// so a read never meets a pending write to the same entry.
	always_comb begin
		req_ready = state_q == ST_IDLE;
		res_valid = state_q == ST_REPORT;
		res.status      = status_q;
		res.entry_count = entry_bits(cnt_q);
		res.table_empty = cnt_q == '0;

		ram_re    = (state_q == ST_SWEEP) && (rd_idx_q < cnt_q);
		ram_raddr = rd_idx_q[IDX_W-1:0];

		ram_we    = 1'b0;
		ram_waddr = rd_pos_s1;
		ram_wdata = carry_q;
		if ((state_q == ST_SWEEP) && rd_vld_s1) begin
			if (op_q == OP_INSERT) begin
				// Shift the tail up by one, new key at the first entry not smaller.
				if (found_q) begin
					ram_we = 1'b1;
				end else if (key_ge) begin
					ram_we    = 1'b1;
					ram_wdata = key_q;
				end
			end else if ((op_q == OP_DELETE) && found_q) begin
				// Shift the tail down by one over the removed entry.
				ram_we    = 1'b1;
				ram_waddr = rd_pos_s1 - idx_t'(1);
				ram_wdata = ram_rdata;
			end
		end else if ((state_q == ST_FINISH) && (op_q == OP_INSERT)) begin
			// The last shifted entry, or the new key when it goes at the end.
			ram_we    = 1'b1;
			ram_waddr = cnt_q[IDX_W-1:0];
			ram_wdata = found_q ? carry_q : key_q;
		end
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			op_q      <= OP_INSERT;
			status_q  <= STAT_MISS;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q     <= req_op;
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						status_q <= req_full ? STAT_FULL : STAT_MISS;
					end
				end
				ST_SWEEP: begin
					if (ram_re) begin
						rd_idx_q <= rd_idx_q + cnt_t'(1);
					end
					if (rd_vld_s1 && !found_q) begin
						if (op_q == OP_INSERT) begin
							found_q <= key_ge;
						end else begin
							found_q <= key_eq;
						end
					end
				end
				ST_FINISH: begin
					if (op_q == OP_INSERT) begin
						cnt_q    <= cnt_q + cnt_t'(1);
						status_q <= STAT_OK;
					end else if (found_q) begin
						if (op_q == OP_DELETE) begin
							cnt_q <= cnt_q - cnt_t'(1);
						end
						status_q <= STAT_OK;
					end
				end
				ST_REPORT: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_pos_s1 <= rd_idx_q[IDX_W-1:0];
		if ((state_q == ST_IDLE) && req_valid) begin
			key_q <= req_key;
		end
		if ((state_q == ST_SWEEP) && rd_vld_s1 && (op_q == OP_INSERT)
			&& (found_q || key_ge)) begin
			carry_q <= ram_rdata;
		end
	end

endmodule

`default_nettype wire

[design/sorted_key_table_top.sv]
// Each request sweeps the stored keys with one key memory read per cycle; a request is taken
// only while idle, so the next one waits until the result has moved to the output register.
// A full-table insert or an unused code skips the sweep and goes straight to the report state.
// A stalled output holds the result in the report state and so delays the next request.
// A new request is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) empties the table; the key memory is not cleared.
`default_nettype none

module sorted_key_table_top
	import skt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] key
	input  wire logic [1:0]  s_tuser,   // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // [1:0] status, [6:2] entry_count, [7] table_empty
);

	logic             res_valid;
	logic             res_ready;
	result_t          res;
	result_t          out_q;
	logic             out_vld_q;
	logic             ram_we;
	idx_t             ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic             ram_re;
	idx_t             ram_raddr;
	logic [KEY_W-1:0] ram_rdata;

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_op    (s_tuser),
		.req_key   ($signed(s_tdata)),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	skt_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_W),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: loads when empty or being drained.
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = RES_W'(out_q);

endmodule

`default_nettype wire

[design/skt_chk.sv]
`default_nettype none

module skt_chk
	import skt_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One request at a time: the port closes right after taking one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request port stayed open after a request");

	// An empty table reports a zero count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[6:2] == 5'd0)
		else $error("empty flag with nonzero count");

	// A rejected insert means the table holds keys.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == STAT_FULL) |-> !m_tdata[7])
		else $error("full status on an empty table");

endmodule

bind sorted_key_table_top skt_chk u_skt_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
